### rtl/rfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

   // parser phases, in frame order
   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_LEN   = 4'd1,
      PH_IDLEN = 4'd2,
      PH_ID    = 4'd3,
      PH_MLEN  = 4'd4,
      PH_METH  = 4'd5,
      PH_ERR   = 4'd6,
      PH_ILEN  = 4'd7,
      PH_INFO  = 4'd8,
      PH_PAY   = 4'd9,
      PH_CKS   = 4'd10,
      PH_END   = 4'd11
   } phase_type;

   // field kinds on the result channel
   localparam logic [3:0] KIND_SKIP   = 4'd0;
   localparam logic [3:0] KIND_START  = 4'd1;
   localparam logic [3:0] KIND_LEN    = 4'd2;
   localparam logic [3:0] KIND_IDLEN  = 4'd3;
   localparam logic [3:0] KIND_ID     = 4'd4;
   localparam logic [3:0] KIND_MLEN   = 4'd5;
   localparam logic [3:0] KIND_METH   = 4'd6;
   localparam logic [3:0] KIND_ERR    = 4'd7;
   localparam logic [3:0] KIND_ILEN   = 4'd8;
   localparam logic [3:0] KIND_INFO   = 4'd9;
   localparam logic [3:0] KIND_PAY    = 4'd10;
   localparam logic [3:0] KIND_CKS    = 4'd11;
   localparam logic [3:0] KIND_END    = 4'd12;

   // frame status codes
   localparam logic [1:0] ST_BUSY    = 2'd0;
   localparam logic [1:0] ST_GOOD    = 2'd1;
   localparam logic [1:0] ST_BAD_END = 2'd2;
   localparam logic [1:0] ST_BAD_LEN = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN      = 2'd2;

   localparam logic [31:0] OVERHEAD_BYTES = 32'd26;
   localparam logic [23:0] WORD_BYTES     = 24'd4;

   typedef struct packed {
      logic [3:0] field_kind;
      logic [7:0] data;
      logic       field_last;
      logic [1:0] frame_status;
   } result_type;

   function automatic logic [3:0] phase_kind(input phase_type ph);
      logic [3:0] k;
      case (ph)
         PH_LEN:   k = KIND_LEN;
         PH_IDLEN: k = KIND_IDLEN;
         PH_ID:    k = KIND_ID;
         PH_MLEN:  k = KIND_MLEN;
         PH_METH:  k = KIND_METH;
         PH_ERR:   k = KIND_ERR;
         PH_ILEN:  k = KIND_ILEN;
         PH_INFO:  k = KIND_INFO;
         PH_PAY:   k = KIND_PAY;
         PH_CKS:   k = KIND_CKS;
         PH_END:   k = KIND_END;
         default:  k = KIND_SKIP;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### rtl/rpc_frame_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// byte-wide parser for length-prefixed rpc frames: every accepted byte gives exactly one
// registered result transaction, tagged with its field, an end-of-field flag and, on
// the closing or offending byte, the frame status; one byte is taken every clock cycle
// while the skid register is empty, limited only by the single parse step between the
// phase/counter registers and the result register, and a two-entry output (result register
// plus skid register) keeps the input open while one result waits; no clearing pass is
// needed after reset, and register writes act at once, also in the middle of a frame
module rpc_frame_deframer_top
   import rfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_field_kind,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_field_last,
   output logic [1:0]       rsp_frame_status,
   // register write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   // configuration
   logic [7:0]  start_marker_ff;
   logic [7:0]  end_marker_ff;
   logic [23:0] max_len_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [23:0] remain_ff, remain_in;   // bytes left in the current field
   logic [31:0] acc_ff, acc_in;         // big-endian word being shifted in
   logic [23:0] budget_ff, budget_in;   // frame length minus overhead minus text so far

   // output buffer
   result_type  out_ff, skid_ff, result;
   logic        out_valid_ff, skid_valid_ff;

   logic        accept, pop;
   logic        is_word, field_done, bad_total, overrun;
   logic [31:0] word_val;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   // config writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'd2;
         end_marker_ff   <= 8'd3;
         max_len_ff      <= 24'd65535;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata[7:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata[7:0];
            CSR_MAX_LEN:      max_len_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared datapath terms
   always_comb begin
      is_word = (phase_ff == PH_LEN) || (phase_ff == PH_IDLEN) || (phase_ff == PH_MLEN) ||
                (phase_ff == PH_ERR) || (phase_ff == PH_ILEN) || (phase_ff == PH_CKS);
      word_val   = is_word ? {acc_ff[23:0], req_data_byte} : acc_ff;
      field_done = (remain_ff == 24'd1);
      bad_total  = (word_val < OVERHEAD_BYTES) || (word_val > {8'd0, max_len_ff});
      overrun    = (word_val > {8'd0, budget_ff});
   end

   // result for the byte at the input
   always_comb begin
      result.field_kind   = KIND_SKIP;
      result.data         = req_data_byte;
      result.field_last   = 1'b0;
      result.frame_status = ST_BUSY;
      case (phase_ff)
         PH_HUNT: begin
            if (req_data_byte == start_marker_ff) begin
               result.field_kind = KIND_START;
               result.field_last = 1'b1;
            end
         end
         PH_END: begin
            result.field_kind   = KIND_END;
            result.field_last   = 1'b1;
            result.frame_status = (req_data_byte == end_marker_ff) ? ST_GOOD : ST_BAD_END;
         end
         default: begin
            result.field_kind = phase_kind(phase_ff);
            result.field_last = field_done;
            if (field_done) begin
               if ((phase_ff == PH_LEN) && bad_total) begin
                  result.frame_status = ST_BAD_LEN;
               end else if (((phase_ff == PH_IDLEN) || (phase_ff == PH_MLEN) ||
                             (phase_ff == PH_ILEN)) && overrun) begin
                  result.frame_status = ST_BAD_LEN;
               end
            end
         end
      endcase
   end

   // next parse state
   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      acc_in    = acc_ff;
      budget_in = budget_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (req_data_byte == start_marker_ff) begin
               phase_in  = PH_LEN;
               remain_in = WORD_BYTES;
               acc_in    = 32'd0;
            end
         end
         PH_END: begin
            phase_in = PH_HUNT;
         end
         default: begin
            acc_in    = word_val;
            remain_in = remain_ff - 24'd1;
            if (field_done) begin
               case (phase_ff)
                  PH_LEN: begin
                     if (bad_total) begin
                        phase_in = PH_HUNT;
                     end else begin
                        budget_in = word_val[23:0] - OVERHEAD_BYTES[23:0];
                        phase_in  = PH_IDLEN;
                        remain_in = WORD_BYTES;
                        acc_in    = 32'd0;
                     end
                  end
                  PH_IDLEN, PH_MLEN, PH_ILEN: begin
                     if (overrun) begin
                        phase_in = PH_HUNT;
                     end else begin
                        budget_in = budget_ff - word_val[23:0];
                        if (word_val != 32'd0) begin
                           remain_in = word_val[23:0];
                           phase_in  = (phase_ff == PH_IDLEN) ? PH_ID :
                                       (phase_ff == PH_MLEN)  ? PH_METH : PH_INFO;
                        end else if (phase_ff == PH_ILEN) begin
                           // empty info, go straight to payload, or to the checksum when no bytes are left
                           if (budget_ff == 24'd0) begin
                              phase_in  = PH_CKS;
                              remain_in = WORD_BYTES;
                              acc_in    = 32'd0;
                           end else begin
                              phase_in  = PH_PAY;
                              remain_in = budget_ff;
                           end
                        end else begin
                           // empty id or method text
                           phase_in  = (phase_ff == PH_IDLEN) ? PH_MLEN : PH_ERR;
                           remain_in = WORD_BYTES;
                           acc_in    = 32'd0;
                        end
                     end
                  end
                  PH_ID: begin
                     phase_in  = PH_MLEN;
                     remain_in = WORD_BYTES;
                     acc_in    = 32'd0;
                  end
                  PH_METH: begin
                     phase_in  = PH_ERR;
                     remain_in = WORD_BYTES;
                     acc_in    = 32'd0;
                  end
                  PH_ERR: begin
                     phase_in  = PH_ILEN;
                     remain_in = WORD_BYTES;
                     acc_in    = 32'd0;
                  end
                  PH_INFO: begin
                     // payload takes whatever is left of the frame
                     if (budget_ff == 24'd0) begin
                        phase_in  = PH_CKS;
                        remain_in = WORD_BYTES;
                        acc_in    = 32'd0;
                     end else begin
                        phase_in  = PH_PAY;
                        remain_in = budget_ff;
                     end
                  end
                  PH_PAY: begin
                     phase_in  = PH_CKS;
                     remain_in = WORD_BYTES;
                     acc_in    = 32'd0;
                  end
                  default: begin
                     // checksum done, one end byte follows
                     phase_in  = PH_END;
                     remain_in = 24'd1;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         remain_ff <= 24'd0;
         acc_ff    <= 32'd0;
         budget_ff <= 24'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
         budget_ff <= budget_in;
      end
   end

   // result register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_field_kind   = out_ff.field_kind;
   assign rsp_byte_out     = out_ff.data;
   assign rsp_field_last   = out_ff.field_last;
   assign rsp_frame_status = out_ff.frame_status;

`ifndef SYNTHESIS
   // skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without result entry");

   // inside a frame the field counter never sits at zero
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HUNT) |-> (remain_ff != 24'd0))
      else $error("field counter empty inside a frame");

   // a start byte while hunting always opens the length word
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_HUNT) && (req_data_byte == start_marker_ff))
      |=> (phase_ff == PH_LEN) && (remain_ff == WORD_BYTES))
      else $error("start byte did not open a frame");

   // a frame status only rides on the last byte of a field
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_status != ST_BUSY)) |-> rsp_field_last)
      else $error("frame status on a byte that does not end its field");
`endif

endmodule

`default_nettype wire
